FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Result kinds, character constants and byte decoding helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int CAP_W  = 13;
    localparam int LEN_W  = 12;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int HEX_W  = 16;

    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
    localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd200;
    localparam logic [LEN_W-1:0] LEN_MAX   = 12'hFFF;
    localparam logic [HEX_W-1:0] ASCII_END = 16'h0080;

    typedef struct packed {
        logic             ok;
        logic [3:0]       value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] b);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            d.value = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            d.value = 4'(b - 8'h37);
        end
        else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [BYTE_W-1:0] escape_map(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        unique case (b)
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] keep_limit(input logic [CAP_W-1:0] cap);
        logic [LEN_W-1:0] r;
        if (cap == '0) begin
            r = '0;
        end
        else if (cap > {1'b0, LEN_MAX} + 13'd1) begin
            r = LEN_MAX;
        end
        else begin
            r = LEN_W'(cap - 13'd1);
        end
        return r;
    endfunction

endpackage

FILE: rtl/json_string_unescaper.sv
// ----------------------------------------------------------------------------
// JSON string unescaper
// Decodes a quoted JSON string literal one byte per request.
// ----------------------------------------------------------------------------
// Input requests on s_* carry one raw byte of the literal, starting at the
// opening quote. Each plain character or completed escape yields one decoded
// byte request on m_* (kind 0), until the kept count reaches the capacity
// minus one; later bytes are dropped. A closing quote yields a completion
// request (kind 1) and malformed input yields kind 2; both carry the kept
// length and return the block to idle, ready for the next literal.
// The cfg channel sets buffer_capacity; the user must see that it is written
// only while idle, as the block does not enforce it. An accepted byte is held
// in the input register, then the decode stage feeds the result register.
// Throughput is one byte per cycle, set by the single decode stage, unless
// the receiver stalls: then the result register holds and the input register
// fills, so at most two requests are held before s_tready drops.
// Reset clears the state to idle, the capacity to 200 and both stages empty.
// ----------------------------------------------------------------------------
module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,   // buffer_capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_byte [7:0], kept_length [19:8], zero fill
    output logic [1:0]  m_tuser     // kind
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_BODY, PH_ESC, PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [HEX_W-1:0]    hex_reg, hex_next;
    logic [LEN_W-1:0]    kept_reg, kept_next;
    logic [LEN_W-1:0]    limit_reg;
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [BYTE_W-1:0]   obyte_reg, obyte_next;
    logic [LEN_W-1:0]    olen_reg, olen_next;
    logic                res_next;
    logic                advance;
    hex_digit_t          hd;
    logic [HEX_W-1:0]    hex_shift;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = kind_reg;
    assign m_tdata   = {4'd0, olen_reg, obyte_reg};

    assign hd        = hex_decode(in_byte_reg);
    assign hex_shift = {hex_reg[HEX_W-5:0], hd.value};

    always_comb
    begin
        logic             do_emit;
        logic [BYTE_W-1:0] emit_byte;
        logic             do_report;
        logic [KIND_W-1:0] report_kind;
        do_emit     = 1'b0;
        emit_byte   = in_byte_reg;
        do_report   = 1'b0;
        report_kind = KIND_BAD;
        phase_next  = phase_reg;
        hex_next    = hex_reg;
        kept_next   = kept_reg;
        res_next    = 1'b0;
        kind_next   = KIND_BYTE;
        obyte_next  = '0;
        olen_next   = kept_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte_reg != CH_QUOTE) begin
                    do_report = 1'b1;
                end
                else begin
                    phase_next = PH_BODY;
                    hex_next   = '0;
                    kept_next  = '0;
                end
            end
            PH_BODY:
            begin
                if (in_byte_reg == CH_NUL) begin
                    do_report = 1'b1;
                end
                else if (in_byte_reg == CH_QUOTE) begin
                    do_report   = 1'b1;
                    report_kind = KIND_DONE;
                end
                else if (in_byte_reg == CH_BSL) begin
                    phase_next = PH_ESC;
                end
                else begin
                    do_emit = 1'b1;
                end
            end
            PH_ESC:
            begin
                if (in_byte_reg == CH_NUL) begin
                    do_report = 1'b1;
                end
                else if (in_byte_reg == CH_U) begin
                    hex_next   = '0;
                    phase_next = PH_HEX1;
                end
                else begin
                    do_emit   = 1'b1;
                    emit_byte = escape_map(in_byte_reg);
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3:
            begin
                if (!hd.ok) begin
                    do_report = 1'b1;
                end
                else begin
                    hex_next   = hex_shift;
                    phase_next = phase_t'(phase_reg + 3'd1);
                end
            end
            PH_HEX4:
            begin
                if (!hd.ok) begin
                    do_report = 1'b1;
                end
                else begin
                    hex_next  = '0;
                    do_emit   = 1'b1;
                    emit_byte = (hex_shift < ASCII_END) ? hex_shift[BYTE_W-1:0] : CH_QMARK;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                hex_next   = '0;
                kept_next  = '0;
            end
        endcase

        if (do_report) begin
            res_next   = 1'b1;
            kind_next  = report_kind;
            olen_next  = kept_reg;
            phase_next = PH_IDLE;
            hex_next   = '0;
            kept_next  = '0;
        end
        else if (do_emit) begin
            phase_next = PH_BODY;
            if (kept_reg < limit_reg) begin
                kept_next  = kept_reg + 12'd1;
                res_next   = 1'b1;
                kind_next  = KIND_BYTE;
                obyte_next = emit_byte;
                olen_next  = kept_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            hex_reg       <= '0;
            kept_reg      <= '0;
            limit_reg     <= keep_limit(CAP_RESET);
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_BYTE;
            obyte_reg     <= '0;
            olen_reg      <= '0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= keep_limit(cfg_data);
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
            end
            else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg     <= phase_next;
                hex_reg       <= hex_next;
                kept_reg      <= kept_next;
                out_valid_reg <= res_next;
                if (res_next) begin
                    kind_reg  <= kind_next;
                    obyte_reg <= obyte_next;
                    olen_reg  <= olen_next;
                end
            end
            else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: dv/json_string_unescaper_checker.sv
// ----------------------------------------------------------------------------
// JSON string unescaper checker
// Watches the configuration, input and result channels of the unescaper. It
// keeps its own model of the decode state, predicts the result requests that
// the accepted input bytes cause and compares every accepted result request
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_string_unescaper_checker
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [2:0] {
        LIT_IDLE,
        LIT_BODY,
        LIT_ESCAPE,
        LIT_HEX1,
        LIT_HEX2,
        LIT_HEX3,
        LIT_HEX4
    } literal_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  length;
    } decoded_t;

    decoded_t          decoded_q[$];
    literal_state_t    lit_state = LIT_IDLE;
    logic [HEX_W-1:0]  code_point = '0;
    logic [LEN_W-1:0]  kept = '0;
    logic [CAP_W-1:0]  capacity = CAP_RESET;
    int                mismatches = 0;
    int                outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    function automatic logic [LEN_W-1:0] byte_limit(input logic [CAP_W-1:0] cap);
        if (cap == '0) begin
            return '0;
        end
        if (cap > 13'd4096) begin
            return LEN_MAX;
        end
        return LEN_W'(cap - 13'd1);
    endfunction

    function automatic int hex_value(input logic [BYTE_W-1:0] b);
        if (b >= "0" && b <= "9") begin
            return int'(b - "0");
        end
        if (b >= "a" && b <= "f") begin
            return int'(b - "a") + 10;
        end
        if (b >= "A" && b <= "F") begin
            return int'(b - "A") + 10;
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic close_literal(input logic [KIND_W-1:0] kind);
        decoded_q.push_back('{kind: kind, data: '0, length: kept});
        lit_state  = LIT_IDLE;
        code_point = '0;
        kept       = '0;
    endtask

    task automatic keep_byte(input logic [BYTE_W-1:0] b);
        lit_state = LIT_BODY;
        if (kept < byte_limit(capacity)) begin
            kept = kept + 1'b1;
            decoded_q.push_back('{kind: KIND_BYTE, data: b, length: kept});
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        int               digit;
        logic [HEX_W-1:0] cp;
        case (lit_state)
            LIT_IDLE:
            begin
                if (b != CH_QUOTE) begin
                    close_literal(KIND_BAD);
                end
                else begin
                    lit_state  = LIT_BODY;
                    code_point = '0;
                    kept       = '0;
                end
            end
            LIT_BODY:
            begin
                if (b == CH_NUL) begin
                    close_literal(KIND_BAD);
                end
                else if (b == CH_QUOTE) begin
                    close_literal(KIND_DONE);
                end
                else if (b == CH_BSL) begin
                    lit_state = LIT_ESCAPE;
                end
                else begin
                    keep_byte(b);
                end
            end
            LIT_ESCAPE:
            begin
                case (b)
                    CH_NUL:  close_literal(KIND_BAD);
                    "n":     keep_byte(8'h0A);
                    "r":     keep_byte(8'h0D);
                    "t":     keep_byte(8'h09);
                    "b":     keep_byte(8'h08);
                    "f":     keep_byte(8'h0C);
                    CH_U:
                    begin
                        code_point = '0;
                        lit_state  = LIT_HEX1;
                    end
                    default: keep_byte(b);
                endcase
            end
            default:
            begin
                digit = hex_value(b);
                if (digit < 0) begin
                    close_literal(KIND_BAD);
                end
                else begin
                    code_point = {code_point[HEX_W-5:0], 4'(digit)};
                    if (lit_state == LIT_HEX4) begin
                        cp         = code_point;
                        code_point = '0;
                        keep_byte((cp < ASCII_END) ? cp[BYTE_W-1:0] : CH_QMARK);
                    end
                    else begin
                        lit_state = literal_state_t'(lit_state + 1'b1);
                    end
                end
            end
        endcase
    endtask

    task automatic check_result();
        decoded_t want;
        if (decoded_q.size() == 0) begin
            report_mismatch("unexpected result request, kind", 0, m_tuser);
        end
        else begin
            want = decoded_q.pop_front();
            if (m_tuser != want.kind) begin
                report_mismatch("kind", want.kind, m_tuser);
            end
            if (m_tdata[7:0] != want.data) begin
                report_mismatch("out_byte", want.data, m_tdata[7:0]);
            end
            if (m_tdata[19:8] != want.length) begin
                report_mismatch("kept_length", want.length, m_tdata[19:8]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lit_state  = LIT_IDLE;
            code_point = '0;
            kept       = '0;
            capacity   = CAP_RESET;
            decoded_q.delete();
            outstanding = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                capacity = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
            outstanding = decoded_q.size();
        end
    end

endmodule

FILE: dv/json_string_unescaper_tb.sv
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Feeds quoted string literals through the unescaper under several capacity
// settings: a short directed sequence first, then mostly well-formed literals
// with random characters, escapes and unicode escapes, mixed with stray bytes
// and broken literals. The sender runs in bursts and the receiver stalls on a
// pattern of its own, with one long hold-off. A checker beside the block
// predicts and compares every result request.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_string_unescaper_tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum int {
        FAULT_NUL_BODY,
        FAULT_NUL_ESCAPE,
        FAULT_NUL_HEX,
        FAULT_BAD_HEX
    } fault_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        hold = 1'b0;

    int          fail_count;
    int          pending;
    int          cycle = 0;
    int          sent_count = 0;
    int          burst_left = 0;

    always #6 clk = ~clk;

    json_string_unescaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    json_string_unescaper_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT) begin
            $display("json_string_unescaper_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        case ((cycle / 97) % 4)
            0:       m_tready <= !hold;
            1:       m_tready <= !hold && ($urandom_range(0, 1) == 0);
            2:       m_tready <= !hold && ($urandom_range(0, 3) == 0);
            default: m_tready <= !hold && ($urandom_range(0, 3) != 0);
        endcase
    end

    // One long stall of the receiver while the sender keeps offering bytes.
    initial
    begin
        wait (sent_count >= 400);
        @(posedge clk);
        hold <= 1'b1;
        repeat (300) @(posedge clk);
        hold <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [12:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == CH_QUOTE || b == CH_BSL);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return "0" + 8'(v);
        end
        return (($urandom_range(0, 1) == 0) ? "a" : "A") + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                   (b >= "A" && b <= "F"));
        return b;
    endfunction

    function automatic logic [7:0] escape_char();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0:       b = "n";
            1:       b = "r";
            2:       b = "t";
            3:       b = "b";
            4:       b = "f";
            5:       b = "/";
            6:       b = CH_QUOTE;
            7:       b = CH_BSL;
            default:
            begin
                do begin
                    b = 8'($urandom_range(1, 255));
                end while (b == CH_U);
            end
        endcase
        return b;
    endfunction

    task automatic send_token();
        int          sel;
        logic [15:0] cp;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            send_byte(plain_byte());
        end
        else if (sel < 8) begin
            send_byte(CH_BSL);
            send_byte(escape_char());
        end
        else begin
            cp = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 127))
                                             : 16'($urandom_range(0, 16'hFFFF));
            send_byte(CH_BSL);
            send_byte(CH_U);
            send_byte(hex_char(cp[15:12]));
            send_byte(hex_char(cp[11:8]));
            send_byte(hex_char(cp[7:4]));
            send_byte(hex_char(cp[3:0]));
        end
    endtask

    task automatic send_fault();
        fault_t     fault;
        fault = fault_t'($urandom_range(0, 3));
        case (fault)
            FAULT_NUL_BODY:   send_byte(CH_NUL);
            FAULT_NUL_ESCAPE:
            begin
                send_byte(CH_BSL);
                send_byte(CH_NUL);
            end
            default:
            begin
                send_byte(CH_BSL);
                send_byte(CH_U);
                repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15))));
                send_byte((fault == FAULT_NUL_HEX) ? CH_NUL : non_hex_byte());
            end
        endcase
    endtask

    task automatic send_literal(input int n_tokens);
        int         fault_at;
        logic [7:0] b;
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (b == CH_QUOTE);
                send_byte(b);
            end
        end
        send_byte(CH_QUOTE);
        fault_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_tokens) : -1;
        for (int i = 0; i < n_tokens; i++) begin
            if (i == fault_at) begin
                send_fault();
                return;
            end
            send_token();
        end
        if (fault_at == n_tokens) begin
            send_fault();
            return;
        end
        send_byte(CH_QUOTE);
    endtask

    initial
    begin
        logic [7:0]  directed[] = '{"A", CH_QUOTE, 8'h01, 8'hFF, CH_BSL, "n",
                                    CH_BSL, CH_U, "0", "0", "7", "F",
                                    CH_BSL, CH_U, "F", "f", "F", "f", CH_QUOTE,
                                    CH_QUOTE, CH_BSL, CH_NUL,
                                    CH_QUOTE, CH_BSL, CH_U, "1", "g"};
        logic [12:0] caps[] = '{13'd1, 13'd2, 13'd0, 13'd4096, 13'd3, 13'd8,
                                13'd8191, 13'd200, 13'd17};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            send_byte(directed[i]);
        end

        foreach (caps[p]) begin
            drain_results();
            write_capacity(caps[p]);
            repeat (11) begin
                send_literal(($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 8));
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("json_string_unescaper_tb OK");
        end
        else begin
            $display("json_string_unescaper_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: json_string_unescaper.f
rtl/jsu_pkg.sv
rtl/json_string_unescaper.sv
dv/json_string_unescaper_checker.sv
dv/json_string_unescaper_tb.sv
